// ===== hdl/skts_pkg.sv =====
`timescale 1ns / 1ps

package skts_pkg;

    // Table geometry, fixed by the index and count field widths
    localparam int TABLE_DEPTH = 1024;
    localparam int IDX_W       = 10;
    localparam int CNT_W       = 11;

    localparam int KEY_W   = 64;
    localparam int FILE_W  = 16;
    localparam int POS_W   = 32;
    localparam int ENTRY_W = KEY_W + FILE_W + POS_W;

    localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(TABLE_DEPTH);

    // Action codes
    localparam logic [1:0] ACT_APPEND = 2'd0;
    localparam logic [1:0] ACT_SEARCH = 2'd1;
    localparam logic [1:0] ACT_READ   = 2'd2;
    localparam logic [1:0] ACT_CLEAR  = 2'd3;

    // Status codes
    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_FULL     = 2'd1;
    localparam logic [1:0] ST_BAD_READ = 2'd2;

    typedef struct packed {
        logic [1:0]              action;
        logic signed [KEY_W-1:0] key_value;
        logic signed [FILE_W-1:0] file_id;
        logic signed [POS_W-1:0] position;
        logic [IDX_W-1:0]        start_index;
        logic [IDX_W-1:0]        entry_index;
    } request_t;

    typedef struct packed {
        logic [1:0]               status;
        logic [CNT_W-1:0]         result_index;
        logic signed [KEY_W-1:0]  entry_key;
        logic signed [FILE_W-1:0] entry_file;
        logic signed [POS_W-1:0]  entry_position;
        logic [CNT_W-1:0]         entry_count;
    } result_t;

    typedef enum logic [1:0] {
        ADDR_START,
        ADDR_START1,
        ADDR_MID,
        ADDR_ENTRY
    } addr_sel_t;

    typedef enum logic [2:0] {
        IDX_ZERO,
        IDX_START,
        IDX_START1,
        IDX_COUNT,
        IDX_LOW,
        IDX_MID
    } idx_sel_t;

    // Controller to datapath
    typedef struct packed {
        logic      load_item;
        logic      ram_we;
        logic      ram_re;
        addr_sel_t addr_sel;
        logic      count_inc;
        logic      count_clr;
        logic      bs_init;
        logic      bs_go_up;
        logic      bs_go_down;
        logic      res_load;
        logic [1:0] res_status;
        idx_sel_t  res_idx_sel;
        logic      res_entry;
    } ctrl_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic [1:0] action;
        logic       full;
        logic       start_ge_count;
        logic       start1_lt_count;
        logic       ridx_ge_count;
        logic       mem_lt_key;
        logic       key_lt_mem;
        logic       low_lt_hp1;
    } dp_status_t;

endpackage

// ===== hdl/skts_ram.sv =====
`timescale 1ns / 1ps

module skts_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     en,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (we)
            begin
                mem[addr] <= wdata;
            end
            else
            begin
                rdata_reg <= mem[addr];
            end
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== hdl/skts_datapath.sv =====
`timescale 1ns / 1ps

module skts_datapath (
    input  logic                clk,
    input  logic                rst_n,
    input  skts_pkg::request_t  request,
    input  skts_pkg::ctrl_cmd_t cmd,
    output skts_pkg::dp_status_t stat,
    output skts_pkg::result_t   result
);

    skts_pkg::request_t item_reg;
    skts_pkg::result_t  res_reg;
    skts_pkg::result_t  res_next;

    logic [skts_pkg::CNT_W-1:0] count_reg;
    logic [skts_pkg::CNT_W-1:0] count_next;
    // binary search bounds: high is kept as high+1 so it never goes negative
    logic [skts_pkg::CNT_W-1:0] low_reg;
    logic [skts_pkg::CNT_W-1:0] hp1_reg;
    logic [skts_pkg::IDX_W-1:0] mid_reg;

    logic [skts_pkg::CNT_W:0]     mid_sum;
    logic [skts_pkg::IDX_W-1:0]   mid_calc;
    logic [skts_pkg::CNT_W-1:0]   start_ext;
    logic [skts_pkg::CNT_W-1:0]   start1;
    logic [skts_pkg::IDX_W-1:0]   ram_addr;
    logic [skts_pkg::ENTRY_W-1:0] ram_wdata;
    logic [skts_pkg::ENTRY_W-1:0] ram_rdata;
    logic signed [skts_pkg::KEY_W-1:0] mem_key;

    assign start_ext = {1'b0, item_reg.start_index};
    assign start1    = start_ext + 1'b1;

    // low < high+1 holds whenever a midpoint is taken, so the sum stays non-negative
    assign mid_sum  = {1'b0, low_reg} + {1'b0, hp1_reg} - 1'b1;
    assign mid_calc = mid_sum[skts_pkg::IDX_W:1];

    always_comb
    begin
        if (cmd.ram_we)
        begin
            ram_addr = count_reg[skts_pkg::IDX_W-1:0];
        end
        else
        begin
            case (cmd.addr_sel)
                skts_pkg::ADDR_START:  ram_addr = item_reg.start_index;
                skts_pkg::ADDR_START1: ram_addr = start1[skts_pkg::IDX_W-1:0];
                skts_pkg::ADDR_MID:    ram_addr = mid_calc;
                skts_pkg::ADDR_ENTRY:  ram_addr = item_reg.entry_index;
                default:               ram_addr = item_reg.entry_index;
            endcase
        end
    end

    assign ram_wdata = {item_reg.key_value, item_reg.file_id, item_reg.position};

    skts_ram #(
        .WIDTH (skts_pkg::ENTRY_W),
        .DEPTH (skts_pkg::TABLE_DEPTH)
    ) u_ram (
        .clk   (clk),
        .en    (cmd.ram_we | cmd.ram_re),
        .we    (cmd.ram_we),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

    assign mem_key = ram_rdata[skts_pkg::ENTRY_W-1 -: skts_pkg::KEY_W];

    assign stat.action          = item_reg.action;
    assign stat.full            = (count_reg >= skts_pkg::DEPTH_CNT);
    assign stat.start_ge_count  = (start_ext >= count_reg);
    assign stat.start1_lt_count = (start1 < count_reg);
    assign stat.ridx_ge_count   = ({1'b0, item_reg.entry_index} >= count_reg);
    assign stat.mem_lt_key      = (mem_key < item_reg.key_value);
    assign stat.key_lt_mem      = (item_reg.key_value < mem_key);
    assign stat.low_lt_hp1      = (low_reg < hp1_reg);

    always_comb
    begin
        count_next = count_reg;
        if (cmd.count_clr)
        begin
            count_next = '0;
        end
        else if (cmd.count_inc)
        begin
            count_next = count_reg + 1'b1;
        end
    end

    always_comb
    begin
        res_next = res_reg;
        if (cmd.res_load)
        begin
            res_next.status = cmd.res_status;
            case (cmd.res_idx_sel)
                skts_pkg::IDX_ZERO:   res_next.result_index = '0;
                skts_pkg::IDX_START:  res_next.result_index = start_ext;
                skts_pkg::IDX_START1: res_next.result_index = start1;
                skts_pkg::IDX_COUNT:  res_next.result_index = count_reg;
                skts_pkg::IDX_LOW:    res_next.result_index = low_reg;
                skts_pkg::IDX_MID:    res_next.result_index = {1'b0, mid_reg};
                default:              res_next.result_index = '0;
            endcase
            if (cmd.res_entry)
            begin
                {res_next.entry_key, res_next.entry_file, res_next.entry_position} =
                    ram_rdata;
            end
            else
            begin
                res_next.entry_key      = '0;
                res_next.entry_file     = '0;
                res_next.entry_position = '0;
            end
            res_next.entry_count = count_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_item)
        begin
            item_reg <= request;
        end
        if (cmd.bs_init)
        begin
            low_reg <= start_ext;
            hp1_reg <= count_reg;
        end
        else if (cmd.bs_go_up)
        begin
            low_reg <= {1'b0, mid_reg} + 1'b1;
        end
        else if (cmd.bs_go_down)
        begin
            hp1_reg <= {1'b0, mid_reg};
        end
        if (cmd.ram_re && cmd.addr_sel == skts_pkg::ADDR_MID)
        begin
            mid_reg <= mid_calc;
        end
        res_reg <= res_next;
    end

    assign result = res_reg;

endmodule

// ===== hdl/skts_ctrl.sv =====
`timescale 1ns / 1ps

module skts_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  skts_pkg::dp_status_t stat,
    output skts_pkg::ctrl_cmd_t  cmd,
    output logic                 busy,
    output logic                 done
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_DISPATCH,
        S_RD_WAIT,
        S_P0,
        S_P1,
        S_BS_ISSUE,
        S_BS_WAIT
    } state_t;

    state_t state_reg, state_next;
    logic   busy_reg, busy_next;
    logic   done_reg, done_next;

    always_comb
    begin
        cmd         = '0;
        cmd.addr_sel    = skts_pkg::ADDR_START;
        cmd.res_status  = skts_pkg::ST_OK;
        cmd.res_idx_sel = skts_pkg::IDX_ZERO;
        state_next  = state_reg;
        busy_next   = busy_reg;
        done_next   = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.load_item = 1'b1;
                    busy_next     = 1'b1;
                    state_next    = S_DISPATCH;
                end
            end

            S_DISPATCH:
            begin
                case (stat.action)
                    skts_pkg::ACT_APPEND:
                    begin
                        cmd.res_load = 1'b1;
                        if (stat.full)
                        begin
                            cmd.res_status = skts_pkg::ST_FULL;
                        end
                        else
                        begin
                            cmd.ram_we    = 1'b1;
                            cmd.count_inc = 1'b1;
                        end
                        done_next  = 1'b1;
                        busy_next  = 1'b0;
                        state_next = S_IDLE;
                    end
                    skts_pkg::ACT_SEARCH:
                    begin
                        if (stat.start_ge_count)
                        begin
                            cmd.res_load    = 1'b1;
                            cmd.res_idx_sel = skts_pkg::IDX_COUNT;
                            done_next       = 1'b1;
                            busy_next       = 1'b0;
                            state_next      = S_IDLE;
                        end
                        else
                        begin
                            cmd.ram_re   = 1'b1;
                            cmd.addr_sel = skts_pkg::ADDR_START;
                            state_next   = S_P0;
                        end
                    end
                    skts_pkg::ACT_READ:
                    begin
                        if (stat.ridx_ge_count)
                        begin
                            cmd.res_load   = 1'b1;
                            cmd.res_status = skts_pkg::ST_BAD_READ;
                            done_next      = 1'b1;
                            busy_next      = 1'b0;
                            state_next     = S_IDLE;
                        end
                        else
                        begin
                            cmd.ram_re   = 1'b1;
                            cmd.addr_sel = skts_pkg::ADDR_ENTRY;
                            state_next   = S_RD_WAIT;
                        end
                    end
                    default:
                    begin
                        cmd.count_clr = 1'b1;
                        cmd.res_load  = 1'b1;
                        done_next     = 1'b1;
                        busy_next     = 1'b0;
                        state_next    = S_IDLE;
                    end
                endcase
            end

            S_RD_WAIT:
            begin
                cmd.res_load  = 1'b1;
                cmd.res_entry = 1'b1;
                done_next     = 1'b1;
                busy_next     = 1'b0;
                state_next    = S_IDLE;
            end

            S_P0:
            begin
                if (!stat.mem_lt_key)
                begin
                    cmd.res_load    = 1'b1;
                    cmd.res_idx_sel = skts_pkg::IDX_START;
                    done_next       = 1'b1;
                    busy_next       = 1'b0;
                    state_next      = S_IDLE;
                end
                else if (stat.start1_lt_count)
                begin
                    cmd.ram_re   = 1'b1;
                    cmd.addr_sel = skts_pkg::ADDR_START1;
                    state_next   = S_P1;
                end
                else
                begin
                    cmd.bs_init = 1'b1;
                    state_next  = S_BS_ISSUE;
                end
            end

            S_P1:
            begin
                if (stat.key_lt_mem)
                begin
                    cmd.res_load    = 1'b1;
                    cmd.res_idx_sel = skts_pkg::IDX_START1;
                    done_next       = 1'b1;
                    busy_next       = 1'b0;
                    state_next      = S_IDLE;
                end
                else
                begin
                    cmd.bs_init = 1'b1;
                    state_next  = S_BS_ISSUE;
                end
            end

            S_BS_ISSUE:
            begin
                if (stat.low_lt_hp1)
                begin
                    cmd.ram_re   = 1'b1;
                    cmd.addr_sel = skts_pkg::ADDR_MID;
                    state_next   = S_BS_WAIT;
                end
                else
                begin
                    cmd.res_load    = 1'b1;
                    cmd.res_idx_sel = skts_pkg::IDX_LOW;
                    done_next       = 1'b1;
                    busy_next       = 1'b0;
                    state_next      = S_IDLE;
                end
            end

            S_BS_WAIT:
            begin
                if (stat.mem_lt_key)
                begin
                    cmd.bs_go_up = 1'b1;
                    state_next   = S_BS_ISSUE;
                end
                else if (stat.key_lt_mem)
                begin
                    cmd.bs_go_down = 1'b1;
                    state_next     = S_BS_ISSUE;
                end
                else
                begin
                    cmd.res_load    = 1'b1;
                    cmd.res_idx_sel = skts_pkg::IDX_MID;
                    done_next       = 1'b1;
                    busy_next       = 1'b0;
                    state_next      = S_IDLE;
                end
            end

            default:
            begin
                busy_next  = 1'b0;
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            busy_reg  <= busy_next;
            done_reg  <= done_next;
        end
    end

    assign busy = busy_reg;
    assign done = done_reg;

endmodule

// ===== hdl/sorted_key_table_search.sv =====
`timescale 1ns / 1ps

// Sorted key table with lower-bound search. A command is taken at the rising
// edge where start is high and busy is low; its one result then appears on
// result, marked by done for exactly one cycle, and must be captured in that
// cycle since there is no way to hold it off. Keys must be appended in
// ascending signed order; that order is the caller's duty and is not checked.
// A search answers at once with the count when its start lies at or beyond
// the entry count; otherwise it probes the key at start, then the key at
// start+1 unless start+1 lies at or beyond the count, and if neither shortcut
// probe answers it runs a binary search of at most 11 steps for a full
// 1024-entry table, stopping early on an equal key. Every probe uses the
// single entry memory with its registered read port: the address is issued
// first and the returned key is compared once registered. A new command may be
// transferred in the same cycle that done is high. Table contents are not
// cleared at reset; only the entry count is, and entries at or beyond the
// count are never read.
module sorted_key_table_search (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  skts_pkg::request_t request,
    output logic               done,
    output skts_pkg::result_t  result
);

    // command and status between the controller and the datapath
    skts_pkg::ctrl_cmd_t  cmd;
    skts_pkg::dp_status_t stat;

    // sequencer: takes the transfer, steps through probes and the search loop
    skts_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .stat  (stat),
        .cmd   (cmd),
        .busy  (busy),
        .done  (done)
    );

    // datapath: holds the command, the entry count, the search bounds, the
    // entry memory and the result register
    skts_datapath u_datapath (
        .clk     (clk),
        .rst_n   (rst_n),
        .request (request),
        .cmd     (cmd),
        .stat    (stat),
        .result  (result)
    );

endmodule

// ===== hdl/skts_checker.sv =====
`timescale 1ns / 1ps

module skts_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               start,
    input logic               busy,
    input skts_pkg::request_t request,
    input logic               done,
    input skts_pkg::result_t  result
);

    // a result is only shown once the block is free again
    a_done_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("done raised while busy");

    // a transfer always occupies the block
    a_take_sets_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("busy not raised after transfer");

    // one result per command, never two in a row
    a_single_strobe: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("done held for more than one cycle");

    // full status only when the table really is full
    a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
        (done && result.status == skts_pkg::ST_FULL) |->
            result.entry_count == skts_pkg::DEPTH_CNT)
        else $error("full status with count below depth");

    // count never exceeds the table depth
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> result.entry_count <= skts_pkg::DEPTH_CNT)
        else $error("entry count beyond depth");

endmodule

bind sorted_key_table_search skts_checker u_checker (.*);
